// File: src/rv64im_decode_execute_unit_defines.svh
// Assertion macros shared by the decode and execute unit.
`ifndef RV64IM_DECODE_EXECUTE_UNIT_DEFINES_SVH
`define RV64IM_DECODE_EXECUTE_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define RVDE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define RVDE_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/rvde_pkg.sv
// Types, codes and pipeline constants of the decode and execute unit.
package rvde_pkg;

    localparam int XLEN       = 64;
    localparam int DIV_STEPS  = XLEN;
    localparam int DIV_LAT    = DIV_STEPS + 2;
    localparam int MUL_LAT    = 2;
    localparam int ALU_LAT    = 1;
    localparam int SIDE_DEPTH = DIV_LAT - ALU_LAT;
    localparam int MUL_DLY    = DIV_LAT - MUL_LAT;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OPW    = 7'h3B;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] INSN_ECALL = 32'h0000_0073;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F6_ALT    = 7'h10;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LBAD = 3'd7;
    localparam logic [2:0] F3_SMAX = 3'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_ECALL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } t_mem_op;

    typedef enum logic [1:0] {
        RES_ALU,
        RES_MUL,
        RES_DIV
    } t_res_sel;

    typedef enum logic [4:0] {
        ALU_NONE,
        ALU_ADD,
        ALU_SUB,
        ALU_SLL,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_SRL,
        ALU_SRA,
        ALU_OR,
        ALU_AND,
        ALU_PASS,
        ALU_AUIPC,
        ALU_LINK,
        ALU_ADDW,
        ALU_SUBW,
        ALU_SLLW,
        ALU_SRLW,
        ALU_SRAW
    } t_alu_op;

    typedef enum logic [3:0] {
        BR_NONE,
        BR_EQ,
        BR_NE,
        BR_LT,
        BR_GE,
        BR_LTU,
        BR_GEU,
        BR_JAL,
        BR_JALR
    } t_br_op;

    typedef struct packed {
        t_status     status;
        logic        write_dest;
        logic [4:0]  dest_index;
        t_alu_op     alu_op;
        t_res_sel    res_sel;
        t_br_op      br_op;
        t_mem_op     mem_op;
        logic [1:0]  mem_size;
        logic        mem_signed;
    } t_ctrl;

    typedef struct packed {
        t_ctrl       ctrl;
        logic [63:0] pc;
        logic [63:0] src1;
        logic [63:0] src2;
        logic [63:0] op2;
        logic [63:0] imm_tgt;
        logic [63:0] store_data;
    } t_dec;

    typedef struct packed {
        t_status     status;
        logic        write_dest;
        logic [4:0]  dest_index;
        t_res_sel    res_sel;
        logic [63:0] result;
        t_mem_op     mem_op;
        logic [1:0]  mem_size;
        logic        mem_signed;
        logic [63:0] store_data;
        logic        redirect;
        logic [63:0] next_pc;
    } t_side;

endpackage

// File: src/rvde_stream_if.sv
// Valid/ready channels that carry instructions in and execution results out.
interface rvde_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] instruction;
    logic        [63:0] pc_value;
    logic signed [63:0] src1_value;
    logic signed [63:0] src2_value;

    modport source (output valid, instruction, pc_value, src1_value, src2_value, input ready);
    modport sink (input valid, instruction, pc_value, src1_value, src2_value, output ready);
endinterface

interface rvde_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic               write_dest;
    logic        [4:0]  dest_index;
    logic signed [63:0] result;
    logic        [1:0]  mem_op;
    logic        [1:0]  mem_size;
    logic               mem_signed;
    logic        [63:0] store_data;
    logic               redirect;
    logic        [63:0] next_pc;

    modport source (output valid, status, write_dest, dest_index, result, mem_op, mem_size,
                    mem_signed, store_data, redirect, next_pc, input ready);
    modport sink (input valid, status, write_dest, dest_index, result, mem_op, mem_size,
                  mem_signed, store_data, redirect, next_pc, output ready);
endinterface

// File: src/rv64im_decode_execute_unit.sv
// Top level of the RV64IM decode and execute unit.
// This unit takes one instruction transaction per clock cycle while the output is not
// stalled and returns one result transaction for each, in order, after it passes a
// decode stage, a sign preparation stage, the radix-2 divider stages (one quotient bit
// per stage), a quotient sign correction stage, and the output register. The divider
// pipeline sets the pipeline depth; every instruction, not only DIV, travels the same
// number of stages so results leave in order. All stages advance together when the
// output register is empty or its transaction is being taken, so a stall at the output
// holds the whole pipeline and input ready follows that condition. Illegal
// words give status 1 with zeroed result fields, ECALL gives status 2, MULH and REM
// count as illegal, DIV by zero returns all ones and the overflow case returns the
// dividend. The block has no configuration and no architectural state.
`include "rv64im_decode_execute_unit_defines.svh"

module rv64im_decode_execute_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rvde_in_if.sink        i_in_ch,
    rvde_out_if.source     o_out_ch
);

    localparam int LAT  = rvde_pkg::DIV_LAT;
    localparam int SD   = rvde_pkg::SIDE_DEPTH;
    localparam int MD   = rvde_pkg::MUL_DLY;

    logic            en;
    logic            dec_valid;
    rvde_pkg::t_dec  dec;
    rvde_pkg::t_side alu_side;
    logic [63:0]     mul_product;
    logic [63:0]     div_quotient;

    // The valid bits travel down the pipeline with their transactions, from decode onward.
    logic            r_vld  [0:LAT-1];
    rvde_pkg::t_side r_side [0:SD-1];
    logic [63:0]     r_mul  [0:MD-1];
    logic            r_out_valid;
    rvde_pkg::t_side r_out;
    rvde_pkg::t_side n_out;

    // The whole pipeline moves when the output register can take a new transaction.
    assign en            = !r_out_valid || o_out_ch.ready;
    assign i_in_ch.ready = en;

    rvde_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_in_ch.valid),
        .i_instruction (i_in_ch.instruction),
        .i_pc_value    (i_in_ch.pc_value),
        .i_src1_value  (i_in_ch.src1_value),
        .i_src2_value  (i_in_ch.src2_value),
        .o_valid       (dec_valid),
        .o_dec         (dec)
    );

    rvde_alu u_alu (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dec  (dec),
        .o_side (alu_side)
    );

    rvde_mul u_mul (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_a       (dec.src1),
        .i_b       (dec.op2),
        .o_product (mul_product)
    );

    rvde_div u_div (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (dec.src1),
        .i_divisor  (dec.op2),
        .o_quotient (div_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= dec_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[LAT-1];
        end
    end

    // Side data of the ALU stage and the product wait here for the quotient.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= alu_side;
            for (int k = 1; k < SD; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_mul[0] <= mul_product;
            for (int k = 1; k < MD; k++) begin
                r_mul[k] <= r_mul[k-1];
            end
            r_out <= n_out;
        end
    end

    always_comb begin
        n_out = r_side[SD-1];
        case (r_side[SD-1].res_sel)
            rvde_pkg::RES_MUL: n_out.result = r_mul[MD-1];
            rvde_pkg::RES_DIV: n_out.result = div_quotient;
            default:           n_out.result = r_side[SD-1].result;
        endcase
    end

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.status     = r_out.status;
    assign o_out_ch.write_dest = r_out.write_dest;
    assign o_out_ch.dest_index = r_out.dest_index;
    assign o_out_ch.result     = r_out.result;
    assign o_out_ch.mem_op     = r_out.mem_op;
    assign o_out_ch.mem_size   = r_out.mem_size;
    assign o_out_ch.mem_signed = r_out.mem_signed;
    assign o_out_ch.store_data = r_out.store_data;
    assign o_out_ch.redirect   = r_out.redirect;
    assign o_out_ch.next_pc    = r_out.next_pc;

    `RVDE_ASSERT(a_ecall_quiet, i_clk, i_rst_n, o_out_ch.valid && (o_out_ch.status == rvde_pkg::ST_ECALL) |-> !o_out_ch.write_dest && (o_out_ch.mem_op == rvde_pkg::MEM_NONE) && !o_out_ch.redirect && (o_out_ch.result == 64'd0), "ecall result carries side effects")
    `RVDE_ASSERT(a_illegal_zero, i_clk, i_rst_n, o_out_ch.valid && (o_out_ch.status == rvde_pkg::ST_ILLEGAL) |-> (o_out_ch.result == 64'd0) && !o_out_ch.redirect && (o_out_ch.store_data == 64'd0), "illegal result not cleared")
    `RVDE_ASSERT(a_no_mem_fields, i_clk, i_rst_n, o_out_ch.valid && (o_out_ch.mem_op != rvde_pkg::MEM_STORE) |-> (o_out_ch.store_data == 64'd0) && ((o_out_ch.mem_op == rvde_pkg::MEM_LOAD) || ((o_out_ch.mem_size == 2'd0) && !o_out_ch.mem_signed)), "memory fields set without access")
    `RVDE_NEVER(a_x0_write, i_clk, i_rst_n, o_out_ch.valid && o_out_ch.write_dest && (o_out_ch.dest_index == 5'd0), "write to register zero flagged")
    `RVDE_ASSERT(a_stall_holds, i_clk, i_rst_n, o_out_ch.valid && !o_out_ch.ready |=> o_out_ch.valid && !i_in_ch.ready || o_out_ch.ready, "stalled output lost its transaction")

endmodule

// File: src/rvde_decode.sv
// Instruction decode stage: control fields, operands and immediates, registered.
module rvde_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic        [31:0] i_instruction,
    input  logic        [63:0] i_pc_value,
    input  logic        [63:0] i_src1_value,
    input  logic        [63:0] i_src2_value,
    output logic               o_valid,
    output rvde_pkg::t_dec     o_dec
);

    logic           r_valid;
    rvde_pkg::t_dec r_dec;
    rvde_pkg::t_dec n_dec;

    always_comb begin
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd;
        logic [63:0] imm_i;
        logic [63:0] imm_s;
        logic [63:0] imm_b;
        logic [63:0] imm_u;
        logic [63:0] imm_j;
        logic        is_imm;
        logic        f7_bad;
        logic [6:0]  hi;
        logic [6:0]  arith;
        logic        wr;
        logic        bad;

        opc    = i_instruction[6:0];
        f3     = i_instruction[14:12];
        f7     = i_instruction[31:25];
        rd     = i_instruction[11:7];
        imm_i  = {{52{i_instruction[31]}}, i_instruction[31:20]};
        imm_s  = {{52{i_instruction[31]}}, i_instruction[31:25], i_instruction[11:7]};
        imm_b  = {{51{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                  i_instruction[30:25], i_instruction[11:8], 1'b0};
        imm_u  = {{32{i_instruction[31]}}, i_instruction[31:12], 12'h000};
        imm_j  = {{43{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                  i_instruction[20], i_instruction[30:21], 1'b0};
        is_imm = (opc == rvde_pkg::OPC_OPIMM) || (opc == rvde_pkg::OPC_OPIMMW);
        f7_bad = !is_imm && (f7 != rvde_pkg::F7_BASE);
        hi     = is_imm ? {1'b0, i_instruction[31:26]} : f7;
        arith  = is_imm ? rvde_pkg::F6_ALT : rvde_pkg::F7_ALT;
        wr     = 1'b0;
        bad    = 1'b0;

        n_dec                 = '0;
        n_dec.ctrl.status     = rvde_pkg::ST_OK;
        n_dec.ctrl.alu_op     = rvde_pkg::ALU_NONE;
        n_dec.ctrl.res_sel    = rvde_pkg::RES_ALU;
        n_dec.ctrl.br_op      = rvde_pkg::BR_NONE;
        n_dec.ctrl.mem_op     = rvde_pkg::MEM_NONE;
        n_dec.pc              = i_pc_value;
        n_dec.src1            = i_src1_value;
        n_dec.src2            = i_src2_value;
        n_dec.op2             = is_imm ? imm_i : i_src2_value;

        unique case (opc) inside
            rvde_pkg::OPC_OP, rvde_pkg::OPC_OPIMM: begin
                wr = 1'b1;
                if (!is_imm && f7 == rvde_pkg::F7_MULDIV) begin
                    if (f3 == rvde_pkg::F3_MUL) begin
                        n_dec.ctrl.res_sel = rvde_pkg::RES_MUL;
                    end else if (f3 == rvde_pkg::F3_DIV) begin
                        n_dec.ctrl.res_sel = rvde_pkg::RES_DIV;
                    end else begin
                        bad = 1'b1;
                    end
                end else begin
                    unique case (f3)
                        rvde_pkg::F3_ADD: begin
                            if (is_imm || f7 == rvde_pkg::F7_BASE) begin
                                n_dec.ctrl.alu_op = rvde_pkg::ALU_ADD;
                            end else if (f7 == rvde_pkg::F7_ALT) begin
                                n_dec.ctrl.alu_op = rvde_pkg::ALU_SUB;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        rvde_pkg::F3_SLL:  n_dec.ctrl.alu_op = rvde_pkg::ALU_SLL;
                        rvde_pkg::F3_SLT:  n_dec.ctrl.alu_op = rvde_pkg::ALU_SLT;
                        rvde_pkg::F3_SLTU: n_dec.ctrl.alu_op = rvde_pkg::ALU_SLTU;
                        rvde_pkg::F3_XOR:  n_dec.ctrl.alu_op = rvde_pkg::ALU_XOR;
                        rvde_pkg::F3_SR: begin
                            if (hi == rvde_pkg::F7_BASE) begin
                                n_dec.ctrl.alu_op = rvde_pkg::ALU_SRL;
                            end else if (hi == arith) begin
                                n_dec.ctrl.alu_op = rvde_pkg::ALU_SRA;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        rvde_pkg::F3_OR:   n_dec.ctrl.alu_op = rvde_pkg::ALU_OR;
                        default:           n_dec.ctrl.alu_op = rvde_pkg::ALU_AND;
                    endcase
                    // Register forms other than add, sub and shifts right need funct7 zero.
                    if (f7_bad && f3 != rvde_pkg::F3_ADD && f3 != rvde_pkg::F3_SR) begin
                        bad = 1'b1;
                    end
                end
            end
            rvde_pkg::OPC_OPW, rvde_pkg::OPC_OPIMMW: begin
                wr = 1'b1;
                if (f3 == rvde_pkg::F3_ADD) begin
                    if (is_imm || f7 == rvde_pkg::F7_BASE) begin
                        n_dec.ctrl.alu_op = rvde_pkg::ALU_ADDW;
                    end else if (f7 == rvde_pkg::F7_ALT) begin
                        n_dec.ctrl.alu_op = rvde_pkg::ALU_SUBW;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (f3 == rvde_pkg::F3_SLL) begin
                    if (f7_bad) begin
                        bad = 1'b1;
                    end else begin
                        n_dec.ctrl.alu_op = rvde_pkg::ALU_SLLW;
                    end
                end else if (f3 == rvde_pkg::F3_SR) begin
                    if (f7 == rvde_pkg::F7_BASE) begin
                        n_dec.ctrl.alu_op = rvde_pkg::ALU_SRLW;
                    end else if (f7 == rvde_pkg::F7_ALT) begin
                        n_dec.ctrl.alu_op = rvde_pkg::ALU_SRAW;
                    end else begin
                        bad = 1'b1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            rvde_pkg::OPC_LUI: begin
                wr                = 1'b1;
                n_dec.op2         = imm_u;
                n_dec.ctrl.alu_op = rvde_pkg::ALU_PASS;
            end
            rvde_pkg::OPC_AUIPC: begin
                wr                = 1'b1;
                n_dec.op2         = imm_u;
                n_dec.ctrl.alu_op = rvde_pkg::ALU_AUIPC;
            end
            rvde_pkg::OPC_JAL: begin
                wr                = 1'b1;
                n_dec.ctrl.alu_op = rvde_pkg::ALU_LINK;
                n_dec.ctrl.br_op  = rvde_pkg::BR_JAL;
                n_dec.imm_tgt     = imm_j;
            end
            rvde_pkg::OPC_JALR: begin
                wr                = 1'b1;
                n_dec.ctrl.alu_op = rvde_pkg::ALU_LINK;
                n_dec.ctrl.br_op  = rvde_pkg::BR_JALR;
                n_dec.imm_tgt     = imm_i;
            end
            rvde_pkg::OPC_BRANCH: begin
                n_dec.imm_tgt = imm_b;
                unique case (f3)
                    rvde_pkg::F3_BEQ:  n_dec.ctrl.br_op = rvde_pkg::BR_EQ;
                    rvde_pkg::F3_BNE:  n_dec.ctrl.br_op = rvde_pkg::BR_NE;
                    rvde_pkg::F3_BLT:  n_dec.ctrl.br_op = rvde_pkg::BR_LT;
                    rvde_pkg::F3_BGE:  n_dec.ctrl.br_op = rvde_pkg::BR_GE;
                    rvde_pkg::F3_BLTU: n_dec.ctrl.br_op = rvde_pkg::BR_LTU;
                    rvde_pkg::F3_BGEU: n_dec.ctrl.br_op = rvde_pkg::BR_GEU;
                    default:           bad = 1'b1;
                endcase
            end
            rvde_pkg::OPC_LOAD: begin
                if (f3 == rvde_pkg::F3_LBAD) begin
                    bad = 1'b1;
                end else begin
                    wr                    = 1'b1;
                    n_dec.op2             = imm_i;
                    n_dec.ctrl.alu_op     = rvde_pkg::ALU_ADD;
                    n_dec.ctrl.mem_op     = rvde_pkg::MEM_LOAD;
                    n_dec.ctrl.mem_size   = f3[1:0];
                    n_dec.ctrl.mem_signed = !f3[2];
                end
            end
            rvde_pkg::OPC_STORE: begin
                if (f3 > rvde_pkg::F3_SMAX) begin
                    bad = 1'b1;
                end else begin
                    n_dec.op2           = imm_s;
                    n_dec.ctrl.alu_op   = rvde_pkg::ALU_ADD;
                    n_dec.ctrl.mem_op   = rvde_pkg::MEM_STORE;
                    n_dec.ctrl.mem_size = f3[1:0];
                    unique case (f3[1:0])
                        2'd0:    n_dec.store_data = {56'h0, i_src2_value[7:0]};
                        2'd1:    n_dec.store_data = {48'h0, i_src2_value[15:0]};
                        2'd2:    n_dec.store_data = {32'h0, i_src2_value[31:0]};
                        default: n_dec.store_data = i_src2_value;
                    endcase
                end
            end
            rvde_pkg::OPC_SYSTEM: begin
                if (i_instruction == rvde_pkg::INSN_ECALL) begin
                    n_dec.ctrl.status = rvde_pkg::ST_ECALL;
                end else begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase

        if (bad) begin
            wr                    = 1'b0;
            n_dec.ctrl.status     = rvde_pkg::ST_ILLEGAL;
            n_dec.ctrl.alu_op     = rvde_pkg::ALU_NONE;
            n_dec.ctrl.res_sel    = rvde_pkg::RES_ALU;
            n_dec.ctrl.br_op      = rvde_pkg::BR_NONE;
            n_dec.ctrl.mem_op     = rvde_pkg::MEM_NONE;
            n_dec.ctrl.mem_size   = 2'd0;
            n_dec.ctrl.mem_signed = 1'b0;
            n_dec.store_data      = '0;
        end

        n_dec.ctrl.dest_index = wr ? rd : 5'd0;
        n_dec.ctrl.write_dest = wr && (rd != 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// File: src/rvde_alu.sv
// Integer ALU, branch compare and target adder, one registered stage.
module rvde_alu (
    input  logic            i_clk,
    input  logic            i_en,
    input  rvde_pkg::t_dec  i_dec,
    output rvde_pkg::t_side o_side
);

    rvde_pkg::t_side r_side;
    rvde_pkg::t_side n_side;

    always_comb begin
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sum;
        logic [63:0] diff;
        logic [31:0] w;
        logic [63:0] link;
        logic [63:0] tgt;
        logic [63:0] jr;
        logic        eq;
        logic        lt;
        logic        ltu;
        logic        take;

        a    = i_dec.src1;
        b    = i_dec.op2;
        sum  = a + b;
        diff = a - b;
        link = i_dec.pc + 64'd4;
        jr   = a + i_dec.imm_tgt;
        tgt  = i_dec.pc + i_dec.imm_tgt;
        eq   = (a == i_dec.src2);
        lt   = ($signed(a) < $signed(i_dec.src2));
        ltu  = (a < i_dec.src2);
        w    = '0;

        n_side.result = '0;
        case (i_dec.ctrl.alu_op)
            rvde_pkg::ALU_ADD:   n_side.result = sum;
            rvde_pkg::ALU_SUB:   n_side.result = diff;
            rvde_pkg::ALU_SLL:   n_side.result = a << b[5:0];
            rvde_pkg::ALU_SLT:   n_side.result = {63'h0, $signed(a) < $signed(b)};
            rvde_pkg::ALU_SLTU:  n_side.result = {63'h0, a < b};
            rvde_pkg::ALU_XOR:   n_side.result = a ^ b;
            rvde_pkg::ALU_SRL:   n_side.result = a >> b[5:0];
            rvde_pkg::ALU_SRA:   n_side.result = $unsigned($signed(a) >>> b[5:0]);
            rvde_pkg::ALU_OR:    n_side.result = a | b;
            rvde_pkg::ALU_AND:   n_side.result = a & b;
            rvde_pkg::ALU_PASS:  n_side.result = b;
            rvde_pkg::ALU_AUIPC: n_side.result = i_dec.pc + b;
            rvde_pkg::ALU_LINK:  n_side.result = link;
            rvde_pkg::ALU_ADDW: begin
                w             = sum[31:0];
                n_side.result = {{32{w[31]}}, w};
            end
            rvde_pkg::ALU_SUBW: begin
                w             = diff[31:0];
                n_side.result = {{32{w[31]}}, w};
            end
            rvde_pkg::ALU_SLLW: begin
                w             = a[31:0] << b[4:0];
                n_side.result = {{32{w[31]}}, w};
            end
            rvde_pkg::ALU_SRLW: begin
                w             = a[31:0] >> b[4:0];
                n_side.result = {{32{w[31]}}, w};
            end
            rvde_pkg::ALU_SRAW: begin
                w             = $unsigned($signed(a[31:0]) >>> b[4:0]);
                n_side.result = {{32{w[31]}}, w};
            end
            default:             n_side.result = '0;
        endcase

        case (i_dec.ctrl.br_op)
            rvde_pkg::BR_EQ:   take = eq;
            rvde_pkg::BR_NE:   take = !eq;
            rvde_pkg::BR_LT:   take = lt;
            rvde_pkg::BR_GE:   take = !lt;
            rvde_pkg::BR_LTU:  take = ltu;
            rvde_pkg::BR_GEU:  take = !ltu;
            rvde_pkg::BR_JAL:  take = 1'b1;
            rvde_pkg::BR_JALR: take = 1'b1;
            default:           take = 1'b0;
        endcase

        n_side.status     = i_dec.ctrl.status;
        n_side.write_dest = i_dec.ctrl.write_dest;
        n_side.dest_index = i_dec.ctrl.dest_index;
        n_side.res_sel    = i_dec.ctrl.res_sel;
        n_side.mem_op     = i_dec.ctrl.mem_op;
        n_side.mem_size   = i_dec.ctrl.mem_size;
        n_side.mem_signed = i_dec.ctrl.mem_signed;
        n_side.store_data = i_dec.store_data;
        n_side.redirect   = take;
        if (!take) begin
            n_side.next_pc = link;
        end else if (i_dec.ctrl.br_op == rvde_pkg::BR_JALR) begin
            n_side.next_pc = {jr[63:1], 1'b0};
        end else begin
            n_side.next_pc = tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n_side;
        end
    end

    assign o_side = r_side;

endmodule

// File: src/rvde_mul.sv
// Two-stage 64 by 64 multiplier that keeps the low 64 bits of the product.
module rvde_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_product
);

    logic [63:0] r_p_ll;
    logic [31:0] r_p_lh;
    logic [31:0] r_p_hl;
    logic [63:0] r_product;
    logic [63:0] n_p_lh;
    logic [63:0] n_p_hl;

    // Only the low halves of the cross products reach the low 64 bits.
    assign n_p_lh = i_a[31:0] * i_b[63:32];
    assign n_p_hl = i_a[63:32] * i_b[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_ll    <= i_a[31:0] * i_b[31:0];
            r_p_lh    <= n_p_lh[31:0];
            r_p_hl    <= n_p_hl[31:0];
            r_product <= r_p_ll + {r_p_lh + r_p_hl, 32'h0};
        end
    end

    assign o_product = r_product;

endmodule

// File: src/rvde_div.sv
// Pipelined signed divider: sign stage, one quotient bit per stage, sign fix.
module rvde_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic [63:0] o_quotient
);

    localparam int W = rvde_pkg::XLEN;
    localparam int N = rvde_pkg::DIV_STEPS;

    // Index 0 holds the magnitudes; index k holds the state after k steps.
    logic [W-1:0] r_rem [0:N];
    logic [W-1:0] r_quo [0:N];
    logic [W-1:0] r_den [0:N];
    logic         r_neg [0:N];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= i_dividend[W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_den[0] <= i_divisor[W-1] ? (~i_divisor + 1'b1) : i_divisor;
            // A zero divisor yields all ones, so the sign must not be applied.
            r_neg[0] <= (i_dividend[W-1] ^ i_divisor[W-1]) && (i_divisor != '0);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [W-1:0] shifted;
        logic         ge;

        assign shifted = {r_rem[k][W-2:0], r_quo[k][W-1]};
        assign ge      = (shifted >= r_den[k]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? (shifted - r_den[k]) : shifted;
                r_quo[k+1] <= {r_quo[k][W-2:0], ge};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_neg[N] ? (~r_quo[N] + 1'b1) : r_quo[N];
        end
    end

    assign o_quotient = r_q;

endmodule

// File: tb/rvde_tb_checker.sv
// Result checker for the decode and execute unit: predicts each instruction and compares.
`timescale 1ns / 1ps

module rvde_tb_checker
    import rvde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvde_in_if          i_in_ch,
    rvde_out_if         i_out_ch,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_done_count
);

    typedef struct packed {
        t_status     status;
        logic        write_dest;
        logic [4:0]  dest_index;
        logic [63:0] result;
        t_mem_op     mem_op;
        logic [1:0]  mem_size;
        logic        mem_signed;
        logic [63:0] store_data;
        logic        redirect;
        logic [63:0] next_pc;
    } t_exec_result;

    t_exec_result expected_results[$];

    function automatic logic [63:0] sext32(input logic [63:0] v);
        sext32 = {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] signed_quotient(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ua, ub, q;
        if (b == '0) return '1;
        if (a == 64'h8000_0000_0000_0000 && b == '1) return a;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q = ua / ub;
        return (a[63] ^ b[63]) ? -q : q;
    endfunction

    function automatic t_exec_result execute_insn(input logic [31:0] ins, input logic [63:0] pc,
                                                  input logic [63:0] a, input logic [63:0] b);
        t_exec_result r;
        logic [6:0]  opc, f7, hi;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j, op2;
        logic        wr, bad, take;
        opc = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; rd = ins[11:7];
        imm_i = {{52{ins[31]}}, ins[31:20]};
        imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_u = {{32{ins[31]}}, ins[31:12], 12'h000};
        imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        r = '0;
        r.status = ST_OK; r.mem_op = MEM_NONE;
        r.next_pc = pc + 64'd4;
        wr = 1'b0; bad = 1'b0; take = 1'b0;
        op2 = b;
        case (opc)
            OPC_OP, OPC_OPIMM: begin
                if (opc == OPC_OPIMM) op2 = imm_i;
                wr = 1'b1;
                if (opc == OPC_OP && f7 == F7_MULDIV) begin
                    if (f3 == F3_MUL) r.result = a * b;
                    else if (f3 == F3_DIV) r.result = signed_quotient(a, b);
                    else bad = 1'b1;
                end else if (f3 == F3_ADD) begin
                    if (opc == OPC_OPIMM || f7 == F7_BASE) r.result = a + op2;
                    else if (f7 == F7_ALT) r.result = a - op2;
                    else bad = 1'b1;
                end else if (f3 == F3_SR) begin
                    hi = (opc == OPC_OPIMM) ? {1'b0, ins[31:26]} : f7;
                    if (hi == 7'd0) r.result = a >> op2[5:0];
                    else if (hi == ((opc == OPC_OPIMM) ? F6_ALT : F7_ALT))
                        r.result = $signed(a) >>> op2[5:0];
                    else bad = 1'b1;
                end else if (opc == OPC_OP && f7 != F7_BASE) begin
                    bad = 1'b1;
                end else begin
                    case (f3)
                        F3_SLL:  r.result = a << op2[5:0];
                        F3_SLT:  r.result = ($signed(a) < $signed(op2)) ? 64'd1 : 64'd0;
                        F3_SLTU: r.result = (a < op2) ? 64'd1 : 64'd0;
                        F3_XOR:  r.result = a ^ op2;
                        F3_OR:   r.result = a | op2;
                        default: r.result = a & op2;
                    endcase
                end
            end
            OPC_OPW, OPC_OPIMMW: begin
                if (opc == OPC_OPIMMW) op2 = imm_i;
                wr = 1'b1;
                if (f3 == F3_ADD) begin
                    if (opc == OPC_OPIMMW || f7 == F7_BASE) r.result = sext32(a + op2);
                    else if (f7 == F7_ALT) r.result = sext32(a - op2);
                    else bad = 1'b1;
                end else if (f3 == F3_SLL) begin
                    if (opc == OPC_OPW && f7 != F7_BASE) bad = 1'b1;
                    else r.result = sext32({32'd0, a[31:0]} << op2[4:0]);
                end else if (f3 == F3_SR) begin
                    if (f7 == F7_BASE) r.result = sext32({32'd0, a[31:0]} >> op2[4:0]);
                    else if (f7 == F7_ALT) r.result = $signed(sext32(a)) >>> op2[4:0];
                    else bad = 1'b1;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_LUI:   begin wr = 1'b1; r.result = imm_u; end
            OPC_AUIPC: begin wr = 1'b1; r.result = pc + imm_u; end
            OPC_JAL: begin
                wr = 1'b1; r.result = pc + 64'd4; r.redirect = 1'b1; r.next_pc = pc + imm_j;
            end
            OPC_JALR: begin
                wr = 1'b1; r.result = pc + 64'd4; r.redirect = 1'b1;
                r.next_pc = (a + imm_i) & ~64'd1;
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: bad = 1'b1;
                endcase
                if (take) begin r.redirect = 1'b1; r.next_pc = pc + imm_b; end
            end
            OPC_LOAD: begin
                if (f3 == F3_LBAD) bad = 1'b1;
                else begin
                    wr = 1'b1; r.mem_op = MEM_LOAD; r.result = a + imm_i;
                    r.mem_size = f3[1:0]; r.mem_signed = ~f3[2];
                end
            end
            OPC_STORE: begin
                if (f3 > F3_SMAX) bad = 1'b1;
                else begin
                    r.mem_op = MEM_STORE; r.result = a + imm_s; r.mem_size = f3[1:0];
                    case (f3[1:0])
                        2'd0:    r.store_data = {56'd0, b[7:0]};
                        2'd1:    r.store_data = {48'd0, b[15:0]};
                        2'd2:    r.store_data = {32'd0, b[31:0]};
                        default: r.store_data = b;
                    endcase
                end
            end
            OPC_SYSTEM: begin
                if (ins == INSN_ECALL) r.status = ST_ECALL;
                else bad = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            r = '0;
            r.status = ST_ILLEGAL; r.mem_op = MEM_NONE;
            r.next_pc = pc + 64'd4;
            wr = 1'b0;
        end
        r.write_dest = wr && (rd != 5'd0);
        r.dest_index = wr ? rd : 5'd0;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_exec_result exp_r, got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_done_count <= 0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready)
                expected_results.push_back(execute_insn(i_in_ch.instruction, i_in_ch.pc_value,
                                                        i_in_ch.src1_value, i_in_ch.src2_value));
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.status     = t_status'(i_out_ch.status);
                got.write_dest = i_out_ch.write_dest;
                got.dest_index = i_out_ch.dest_index;
                got.result     = i_out_ch.result;
                got.mem_op     = t_mem_op'(i_out_ch.mem_op);
                got.mem_size   = i_out_ch.mem_size;
                got.mem_signed = i_out_ch.mem_signed;
                got.store_data = i_out_ch.store_data;
                got.redirect   = i_out_ch.redirect;
                got.next_pc    = i_out_ch.next_pc;
                o_done_count <= o_done_count + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("checker: result transaction with nothing expected: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    // A field-wise compare via the packed struct, x bits included.
                    if (got !== exp_r) begin
                        if (o_fail_count < 10) begin
                            $display("checker: mismatch at result %0d", o_done_count);
                            $display("  expected %p", exp_r);
                            $display("  actual   %p", got);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/rv64im_decode_execute_unit_tb.sv
// Top of the decode and execute unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rv64im_decode_execute_unit_tb;
    import rvde_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, done_count, sent_count;
    longint cycle_count;

    rvde_in_if  in_ch ();
    rvde_out_if out_ch ();

    rv64im_decode_execute_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch.sink),
        .o_out_ch (out_ch.source)
    );

    rvde_tb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_done_count (done_count)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("rv64im_decode_execute_unit_tb: done, errors");
            $finish;
        end
    end

    // The result side stalls at random; each transaction draws its own stall length,
    // and nearly half of the time the stall is zero so back-to-back takes occur.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // Puts one instruction transaction on the input and holds it until accepted.
    // The valid line is lowered only when a gap follows, never toggled within a step.
    task automatic send_insn(input logic [31:0] ins, input logic [63:0] pc,
                             input logic [63:0] a, input logic [63:0] b);
        int gap;
        gap = $urandom_range(0, 3);
        if (sent_count % 200 < 40) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.instruction <= ins;
        in_ch.pc_value    <= pc;
        in_ch.src1_value  <= a;
        in_ch.src2_value  <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = 64'h7FFF_FFFF_FFFF_FFFF;
            4: v = {32'd0, $urandom_range(0, 70)};
            default: ;
        endcase
        return v;
    endfunction

    // Builds a mostly well-formed word; funct fields and high bits are drawn so that
    // both the legal encodings and their illegal neighbors appear.
    function automatic logic [31:0] rand_insn();
        logic [6:0] opcodes [12];
        logic [31:0] w;
        logic [6:0] f7;
        opcodes = '{OPC_OP, OPC_OPIMM, OPC_OPW, OPC_OPIMMW, OPC_LUI, OPC_AUIPC,
                    OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE, OPC_SYSTEM};
        w = $urandom();
        if ($urandom_range(0, 19) == 0) return w;
        w[6:0] = opcodes[$urandom_range(0, 11)];
        case ($urandom_range(0, 5))
            0: f7 = F7_ALT;
            1: f7 = F7_MULDIV;
            2: f7 = {1'b0, 6'h10} | {6'd0, w[25]};
            3: f7 = w[31:25];
            default: f7 = F7_BASE;
        endcase
        if (w[6:0] != OPC_LUI && w[6:0] != OPC_AUIPC && w[6:0] != OPC_JAL)
            w[31:25] = (w[6:0] == OPC_BRANCH || w[6:0] == OPC_STORE
                        || w[6:0] == OPC_JALR || w[6:0] == OPC_LOAD) ? w[31:25] : f7;
        if (w[6:0] == OPC_SYSTEM && $urandom_range(0, 1) == 1) w = INSN_ECALL;
        return w;
    endfunction

    initial begin
        logic [31:0] directed [$];
        i_rst_n = 1'b0;
        sent_count = 0;
        in_ch.valid = 1'b0;
        in_ch.instruction = '0;
        in_ch.pc_value = '0;
        in_ch.src1_value = '0;
        in_ch.src2_value = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: DIV by zero and overflow, MUL, shifts at full amount, word shift,
        // SRAI/SRAIW, bad SRLI high bits, LWU, LD, SD, jumps, a branch, ecall, an
        // illegal system word, MULH and REM, x0 destinations of ADD and LUI, and an all-ones word.
        directed = '{32'h0220_C0B3, 32'h0220_C0B3, 32'h0220_80B3, 32'h03F0_9093,
                     32'h43F0_D093, 32'h41F0_D09B, 32'h0810_D093, 32'h0000_E083,
                     32'h0000_B083, 32'h0020_B023, 32'hFFFF_F0EF, 32'hFFF0_80E7,
                     32'hFE20_8EE3, INSN_ECALL, 32'h0010_0073, 32'h0220_90B3,
                     32'h0220_E0B3, 32'h0020_8033, 32'hFFFF_F037, 32'hFFFF_FFFF};
        send_insn(directed[0], '1, 64'h1234, 64'd0);
        send_insn(directed[1], 64'h0, 64'h8000_0000_0000_0000, '1);
        for (int i = 2; i < directed.size(); i++)
            send_insn(directed[i], (i % 2) ? '1 : 64'h8000_0000_0000_0000, '1,
                      64'h8000_0000_0000_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_insn(rand_insn(), rand64(), rand64(), rand64());
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d instructions (directed edge cases, then random words)",
                 sent_count);
        $display("%0d results checked, %0d mismatches", done_count, fail_count);
        if (fail_count == 0) begin
            $display("rv64im_decode_execute_unit_tb: done, clean");
        end else begin
            $display("rv64im_decode_execute_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/rvde_pkg.sv
src/rvde_stream_if.sv
src/rvde_decode.sv
src/rvde_alu.sv
src/rvde_mul.sv
src/rvde_div.sv
src/rv64im_decode_execute_unit.sv
tb/rvde_tb_checker.sv
tb/rv64im_decode_execute_unit_tb.sv
